### src/erc_pkg.sv
// Shared types, constants and codes of the event rate counter bank.
package erc_pkg;

	localparam int unsigned DEF_NUM_COUNTERS = 64;
	localparam int unsigned NUM_INTERVALS    = 4;

	localparam int unsigned CMD_W = 3;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned INC_W = 32;
	localparam int unsigned SEL_W = 2;
	localparam int unsigned VAL_W = 64;
	localparam int unsigned CFG_W = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// timebase: seconds in a minute, minutes in an hour, hours in a day
	localparam logic [5:0] SEC_LAST  = 6'd59;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [4:0] HOUR_LAST = 5'd23;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 3'd0,
		CMD_DIFF = 3'd1,
		CMD_TICK = 3'd2,
		CMD_RATE = 3'd3,
		CMD_CUR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ADDR_IN,
		ADDR_ITEM,
		ADDR_ROW
	} addr_sel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SW_RD,
		ST_SW_DIFF,
		ST_SW_WR,
		ST_TICK_DONE
	} state_t;

	typedef struct packed {
		logic      clear_we;
		logic      accept;
		logic      exec_commit;
		logic      diff_en;
		logic      sweep_we;
		logic      out_tick;
		logic      row_rst;
		logic      row_inc;
		addr_sel_t addr_sel;
	} ctl_t;

	typedef struct packed {
		logic out_free;
		logic in_is_tick;
		logic row_last_all;
		logic row_last_act;
		logic active_zero;
	} sts_t;

endpackage

### src/erc_if.sv
// Channel interfaces: command words in, result words out, configuration writes.
interface erc_req_if;
	logic                               valid;
	logic                               ready;
	logic        [erc_pkg::CMD_W-1:0]   cmd;
	logic        [erc_pkg::IDX_W-1:0]   counter_index;
	logic signed [erc_pkg::INC_W-1:0]   increment;
	logic        [erc_pkg::SEL_W-1:0]   interval_select;

	modport source (output valid, cmd, counter_index, increment, interval_select,
		input ready);
	modport sink (input valid, cmd, counter_index, increment, interval_select,
		output ready);
endinterface

interface erc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [erc_pkg::VAL_W-1:0] value;
	logic                             status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

interface erc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [erc_pkg::CFG_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/erc_ctrl.sv
// Controller state machine: sequences clear pass, commands and tick sweeps.
module erc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  erc_pkg::sts_t sts,
	output erc_pkg::ctl_t ctl
);

	erc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.addr_sel = erc_pkg::ADDR_ROW;
		unique case (state_q)
			erc_pkg::ST_CLEAR: begin
				ctl.clear_we = 1'b1;
				if (sts.row_last_all) begin
					ctl.row_rst = 1'b1;
					state_d     = erc_pkg::ST_IDLE;
				end else begin
					ctl.row_inc = 1'b1;
				end
			end
			erc_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				ctl.addr_sel = erc_pkg::ADDR_IN;
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (sts.in_is_tick) begin
						ctl.row_rst = 1'b1;
						state_d     = sts.active_zero ? erc_pkg::ST_TICK_DONE
							: erc_pkg::ST_SW_RD;
					end else begin
						state_d = erc_pkg::ST_EXEC;
					end
				end
			end
			erc_pkg::ST_EXEC: begin
				// memory writes and result load happen together, once the slot is free
				ctl.addr_sel = erc_pkg::ADDR_ITEM;
				if (sts.out_free) begin
					ctl.exec_commit = 1'b1;
					state_d         = erc_pkg::ST_IDLE;
				end
			end
			erc_pkg::ST_SW_RD: begin
				state_d = erc_pkg::ST_SW_DIFF;
			end
			erc_pkg::ST_SW_DIFF: begin
				ctl.diff_en = 1'b1;
				state_d     = erc_pkg::ST_SW_WR;
			end
			erc_pkg::ST_SW_WR: begin
				ctl.sweep_we = 1'b1;
				if (sts.row_last_act) begin
					state_d = erc_pkg::ST_TICK_DONE;
				end else begin
					ctl.row_inc = 1'b1;
					state_d     = erc_pkg::ST_SW_RD;
				end
			end
			erc_pkg::ST_TICK_DONE: begin
				if (sts.out_free) begin
					ctl.out_tick = 1'b1;
					state_d      = erc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = erc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/erc_dp.sv
// Datapath: counter memories, timebase, sweep arithmetic and result register.
module erc_dp #(
	parameter int unsigned NUM_COUNTERS = erc_pkg::DEF_NUM_COUNTERS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic        [erc_pkg::CMD_W-1:0]   in_cmd,
	input  logic        [erc_pkg::IDX_W-1:0]   in_counter_index,
	input  logic signed [erc_pkg::INC_W-1:0]   in_increment,
	input  logic        [erc_pkg::SEL_W-1:0]   in_interval_select,
	input  logic                               cfg_valid,
	input  logic        [erc_pkg::CFG_W-1:0]   cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [erc_pkg::VAL_W-1:0]   out_value,
	output logic                               out_status,
	input  erc_pkg::ctl_t                      ctl,
	output erc_pkg::sts_t                      sts
);

	localparam int unsigned AW    = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_COUNTERS + 1);
	localparam int unsigned LIM_W = (CNT_W > erc_pkg::CFG_W) ? CNT_W : erc_pkg::CFG_W;
	localparam int unsigned NI    = erc_pkg::NUM_INTERVALS;
	localparam int unsigned VW    = erc_pkg::VAL_W;

	typedef logic [NI-1:0][VW-1:0] row_t;

	// configuration
	logic [erc_pkg::CFG_W-1:0] cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= erc_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	logic [LIM_W-1:0] cfg_ext, active, active_m1;
	assign cfg_ext   = LIM_W'(cfg_q);
	assign active    = (cfg_ext > LIM_W'(NUM_COUNTERS)) ? LIM_W'(NUM_COUNTERS) : cfg_ext;
	assign active_m1 = active - LIM_W'(1);

	// item registers
	logic [erc_pkg::CMD_W-1:0] cmd_q;
	logic [erc_pkg::IDX_W-1:0] idx_q;
	logic [erc_pkg::INC_W-1:0] inc_q;
	logic [erc_pkg::SEL_W-1:0] sel_q;
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= in_cmd;
			idx_q <= in_counter_index;
			inc_q <= in_increment;
			sel_q <= in_interval_select;
		end
	end

	// row counter for clear pass and tick sweep
	logic [AW-1:0] row_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.row_rst) begin
			row_q <= '0;
		end else if (ctl.row_inc) begin
			row_q <= row_q + AW'(1);
		end
	end

	// timebase: seconds, minutes, hours of the day position
	logic [5:0] sec_q, min_q;
	logic [4:0] hour_q;
	logic       sec_wrap, min_wrap, hour_wrap, tick_acc;
	logic [NI-1:0] exp_q;
	assign tick_acc  = ctl.accept && sts.in_is_tick;
	assign sec_wrap  = sec_q == erc_pkg::SEC_LAST;
	assign min_wrap  = sec_wrap && (min_q == erc_pkg::MIN_LAST);
	assign hour_wrap = min_wrap && (hour_q == erc_pkg::HOUR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			min_q  <= '0;
			hour_q <= '0;
		end else if (tick_acc) begin
			sec_q <= sec_wrap ? 6'd0 : sec_q + 6'd1;
			if (sec_wrap) begin
				min_q <= min_wrap ? 6'd0 : min_q + 6'd1;
			end
			if (min_wrap) begin
				hour_q <= hour_wrap ? 5'd0 : hour_q + 5'd1;
			end
		end
	end

	// expiry flags of the new position: second always, then minute, hour, day
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			exp_q <= {hour_wrap, min_wrap, sec_wrap, 1'b1};
		end
	end

	// memory address
	logic [LIM_W-1:0] in_idx_ext, idx_ext;
	logic [AW-1:0]    addr;
	assign in_idx_ext = LIM_W'(in_counter_index);
	assign idx_ext    = LIM_W'(idx_q);
	always_comb begin
		case (ctl.addr_sel)
			erc_pkg::ADDR_IN:   addr = in_idx_ext[AW-1:0];
			erc_pkg::ADDR_ITEM: addr = idx_ext[AW-1:0];
			default:            addr = row_q;
		endcase
	end

	// command decode
	logic err, cmd_known, commit_add, commit_diff;
	assign cmd_known   = (cmd_q == erc_pkg::CMD_ADD) || (cmd_q == erc_pkg::CMD_DIFF)
		|| (cmd_q == erc_pkg::CMD_RATE) || (cmd_q == erc_pkg::CMD_CUR);
	assign err         = cmd_known && (idx_ext >= active);
	assign commit_add  = ctl.exec_commit && !err && (cmd_q == erc_pkg::CMD_ADD);
	assign commit_diff = ctl.exec_commit && !err && (cmd_q == erc_pkg::CMD_DIFF);

	// memories, read data registered
	logic [VW-1:0] cnt_mem  [NUM_COUNTERS];
	logic [VW-1:0] last_mem [NUM_COUNTERS];
	row_t          rate_mem [NUM_COUNTERS];
	row_t          mark_mem [NUM_COUNTERS];
	logic [VW-1:0] rd_cnt_q, rd_last_q;
	row_t          rd_rate_q, rd_mark_q;
	row_t          new_rate, new_mark;
	logic [VW-1:0] inc_ext;
	assign inc_ext = {{(VW - erc_pkg::INC_W){inc_q[erc_pkg::INC_W-1]}}, inc_q};

	always_ff @(posedge clk) begin
		if (ctl.clear_we) begin
			cnt_mem[addr] <= '0;
		end else if (commit_add) begin
			cnt_mem[addr] <= rd_cnt_q + inc_ext;
		end
		rd_cnt_q <= cnt_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.clear_we) begin
			last_mem[addr] <= '0;
		end else if (commit_diff) begin
			last_mem[addr] <= rd_cnt_q;
		end
		rd_last_q <= last_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.clear_we) begin
			rate_mem[addr] <= '0;
		end else if (ctl.sweep_we) begin
			rate_mem[addr] <= new_rate;
		end
		rd_rate_q <= rate_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.clear_we) begin
			mark_mem[addr] <= '0;
		end else if (ctl.sweep_we) begin
			mark_mem[addr] <= new_mark;
		end
		rd_mark_q <= mark_mem[addr];
	end

	// sweep: interval deltas first, then rate roll-up into the next interval
	row_t d_q;
	always_ff @(posedge clk) begin
		if (ctl.diff_en) begin
			for (int i = 0; i < NI; i++) begin
				d_q[i] <= rd_cnt_q - rd_mark_q[i];
			end
		end
	end

	always_comb begin
		new_rate[0] = d_q[0];
		new_mark[0] = rd_cnt_q;
		for (int i = 1; i < NI; i++) begin
			if (exp_q[i]) begin
				new_rate[i] = d_q[i];
			end else if (exp_q[i-1]) begin
				new_rate[i] = rd_rate_q[i] + d_q[i-1];
			end else begin
				new_rate[i] = rd_rate_q[i];
			end
			new_mark[i] = exp_q[i] ? rd_cnt_q : rd_mark_q[i];
		end
	end

	// result of an indexed command
	logic [VW-1:0] res_value;
	always_comb begin
		res_value = '0;
		if (!err) begin
			case (cmd_q)
				erc_pkg::CMD_DIFF: res_value = rd_cnt_q - rd_last_q;
				erc_pkg::CMD_RATE: res_value = rd_rate_q[sel_q];
				erc_pkg::CMD_CUR:  res_value = rd_cnt_q;
				default:           res_value = '0;
			endcase
		end
	end

	// output word register
	logic          out_valid_q;
	logic [VW-1:0] value_q;
	logic          status_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec_commit || ctl.out_tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec_commit) begin
			value_q  <= res_value;
			status_q <= err;
		end else if (ctl.out_tick) begin
			value_q  <= '0;
			status_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = value_q;
	assign out_status = status_q;

	assign sts.out_free     = !out_valid_q || out_ready;
	assign sts.in_is_tick   = in_cmd == erc_pkg::CMD_TICK;
	assign sts.row_last_all = row_q == AW'(NUM_COUNTERS - 1);
	assign sts.row_last_act = LIM_W'(row_q) == active_m1;
	assign sts.active_zero  = active == '0;

endmodule

### src/event_rate_counter_bank_top.sv
// Top level of the event rate counter bank.
//
// req carries one command word (add, difference, tick, read rate, read
// current); rsp returns exactly one result word per command, in order.
// cfg writes counters_in_use at any edge with cfg.valid; cfg.ready is always
// high. Write it only while no command is in flight.
// Non-tick command: the counter memories are read at acceptance; in the
// execute state the write-back and the result load happen together once the
// output register is free, and only then does the block take a new word.
// Tick: the sweep visits each counter in use with a read, a delta and a
// write-back step on the shared row port; the tick result is loaded once the
// sweep ends and the output register is free; then a new word is taken.
// After reset a clearing pass zeroes all memories, one row a cycle;
// req.ready stays low meanwhile.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and waits before its write-back until the
// output register is free.
module event_rate_counter_bank_top #(
	parameter int unsigned NUM_COUNTERS = erc_pkg::DEF_NUM_COUNTERS
) (
	input logic       clk,
	input logic       arst_n,
	erc_req_if.sink   req,
	erc_rsp_if.source rsp,
	erc_cfg_if.sink   cfg
);

	erc_pkg::ctl_t ctl;
	erc_pkg::sts_t sts;
	logic          in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	erc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	erc_dp #(
		.NUM_COUNTERS (NUM_COUNTERS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_cmd             (req.cmd),
		.in_counter_index   (req.counter_index),
		.in_increment       (req.increment),
		.in_interval_select (req.interval_select),
		.cfg_valid          (cfg.valid),
		.cfg_data           (cfg.data),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.out_value          (rsp.value),
		.out_status         (rsp.status),
		.ctl                (ctl),
		.sts                (sts)
	);

endmodule

### src/erc_checker.sv
// Port-level assertions for the event rate counter bank, bound to the top level.
module erc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [erc_pkg::VAL_W-1:0] rsp_value,
	input logic                             rsp_status
);

	// result word stays offered while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
		else $error("result word changed while stalled");

	// one command at a time: no acceptance in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command word accepted back to back");

	// an index error never carries a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_value == '0)
		else $error("error result with nonzero value");

endmodule

bind event_rate_counter_bank_top erc_checker u_erc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_status (rsp.status)
);

### bench/tb_event_rate_counter_bank_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the event rate counter bank: directed rows, timebase walk, random.
module tb_event_rate_counter_bank_top;

	localparam int NCNT = erc_pkg::DEF_NUM_COUNTERS;
	localparam int NIV  = erc_pkg::NUM_INTERVALS;

	localparam int unsigned SECS_MIN  = 60;
	localparam int unsigned SECS_HOUR = 60 * 60;
	localparam int unsigned SECS_DAY  = 24 * 60 * 60;

	localparam logic [1:0] IV_SEC  = 2'd0;
	localparam logic [1:0] IV_MIN  = 2'd1;
	localparam logic [1:0] IV_HOUR = 2'd2;
	localparam logic [1:0] IV_DAY  = 2'd3;

	localparam logic STS_OK    = 1'b0;
	localparam logic STS_RANGE = 1'b1;

	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	localparam logic [6:0] CFG_NONE = 7'd0;
	localparam logic [6:0] CFG_ONE  = 7'd1;
	localparam logic [6:0] CFG_MAX  = 7'd127;

	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 400;

	typedef struct packed {
		logic signed [63:0] value;
		logic               status;
	} result_t;

	// one row of the directed table; cfg rows write the register instead of sending a word
	typedef struct packed {
		logic               is_cfg;
		logic [6:0]         cfg_val;
		logic [2:0]         cmd;
		logic [5:0]         idx;
		logic signed [31:0] inc;
		logic [1:0]         sel;
		logic               typed;
		logic signed [63:0] value;
		logic               status;
	} step_t;

	logic clk;
	logic arst_n;

	erc_req_if req_ch ();
	erc_rsp_if rsp_ch ();
	erc_cfg_if cfg_ch ();

	event_rate_counter_bank_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predicted bank state
	bit [63:0]   cnt_now  [NCNT];
	bit [63:0]   cnt_seen [NCNT];
	bit [63:0]   iv_rate  [NCNT][NIV];
	bit [63:0]   iv_mark  [NCNT][NIV];
	int unsigned day_pos;
	logic [6:0]  active_cfg;

	result_t owed_results[$];
	step_t   dir_steps[$];

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_go;
	bit hold_taken;
	int hold_left;

	int fail_count;
	int checked;
	int range_errors;
	int minute_wraps;
	int cfg_writes;
	int cmd_hits [8];

	function automatic int unsigned counters_live();
		return (active_cfg > NCNT) ? NCNT : active_cfg;
	endfunction

	function automatic void roll_interval(int c, int iv);
		bit [63:0] delta;
		delta = cnt_now[c] - iv_mark[c][iv];
		iv_rate[c][iv] = delta;
		iv_mark[c][iv] = cnt_now[c];
		if (iv + 1 < NIV)
			iv_rate[c][iv + 1] += delta;
	endfunction

	function automatic result_t bank_execute(logic [2:0] cmd, logic [5:0] idx,
		logic signed [31:0] inc, logic [1:0] sel);
		result_t r;
		int unsigned n;
		r.value = '0;
		r.status = STS_OK;
		n = counters_live();
		cmd_hits[cmd]++;
		if (cmd == erc_pkg::CMD_TICK) begin
			day_pos = (day_pos + 1 >= SECS_DAY) ? 0 : day_pos + 1;
			if (day_pos % SECS_MIN == 0)
				minute_wraps++;
			for (int c = 0; c < n; c++) begin
				roll_interval(c, IV_SEC);
				if (day_pos % SECS_MIN == 0)
					roll_interval(c, IV_MIN);
				if (day_pos % SECS_HOUR == 0)
					roll_interval(c, IV_HOUR);
				if (day_pos % SECS_DAY == 0)
					roll_interval(c, IV_DAY);
			end
		end else if (cmd <= erc_pkg::CMD_CUR) begin
			if (idx >= n) begin
				r.status = STS_RANGE;
				range_errors++;
			end else begin
				case (cmd)
					erc_pkg::CMD_ADD: cnt_now[idx] += {{32{inc[31]}}, inc};
					erc_pkg::CMD_DIFF: begin
						r.value = cnt_now[idx] - cnt_seen[idx];
						cnt_seen[idx] = cnt_now[idx];
					end
					erc_pkg::CMD_RATE: r.value = iv_rate[idx][sel];
					default: r.value = cnt_now[idx];
				endcase
			end
		end
		return r;
	endfunction

	// offer one command word; prediction is taken at the accepting edge
	task automatic push_word(input logic [2:0] cmd, input logic [5:0] idx,
		input logic signed [31:0] inc, input logic [1:0] sel, input logic typed = 1'b0,
		input logic signed [63:0] tval = '0, input logic tst = STS_OK);
		int gap;
		result_t r;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.counter_index <= idx;
		req_ch.increment <= inc;
		req_ch.interval_select <= sel;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = bank_execute(cmd, idx, inc, sel);
		if (typed) begin
			r.value = tval;
			r.status = tst;
		end
		owed_results.push_back(r);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_active(input logic [6:0] n);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= n;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		active_cfg = n;
		cfg_writes++;
		@(posedge clk);
	endtask

	// walk the day position with no counters in use, so each tick is cheap
	task automatic tick_to(input int unsigned target);
		set_active(CFG_NONE);
		while (day_pos != target)
			push_word(erc_pkg::CMD_TICK, 6'($urandom()), $urandom(), 2'($urandom()));
	endtask

	task automatic push_random();
		logic [2:0] cmd;
		logic [5:0] idx;
		logic signed [31:0] inc;
		int pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 36)
			cmd = erc_pkg::CMD_ADD;
		else if (pick < 50)
			cmd = erc_pkg::CMD_DIFF;
		else if (pick < 54)
			cmd = erc_pkg::CMD_TICK;
		else if (pick < 74)
			cmd = erc_pkg::CMD_RATE;
		else if (pick < 97)
			cmd = erc_pkg::CMD_CUR;
		else
			cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
		n = counters_live();
		if (n > 0 && $urandom_range(9) < 8)
			idx = 6'($urandom_range(n - 1));
		else
			idx = 6'($urandom());
		case ($urandom_range(3))
			0: inc = 32'($urandom_range(16)) - 32'd8;
			1: inc = $urandom();
			2: inc = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: inc = $urandom_range(1000);
		endcase
		push_word(cmd, idx, inc, 2'($urandom()));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left = 0;
			hold_taken = 1'b0;
		end else begin
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: value %h status %0d",
						rsp_ch.value, rsp_ch.status);
			end else begin
				want = owed_results.pop_front();
				if (rsp_ch.value !== want.value || rsp_ch.status !== want.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("word %0d: expected value %h status %0d, got value %h status %0d",
							checked, want.value, want.status, rsp_ch.value, rsp_ch.status);
				end
			end
			checked++;
		end
	end

	initial begin
		#(50_000_000);
		$display("timeout with %0d results outstanding", owed_results.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		step_t s;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.counter_index = '0;
		req_ch.increment = '0;
		req_ch.interval_select = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		day_pos = 0;
		active_cfg = erc_pkg::CFG_RESET;
		fail_count = 0;
		checked = 0;
		range_errors = 0;
		minute_wraps = 0;
		cfg_writes = 0;
		foreach (cmd_hits[i])
			cmd_hits[i] = 0;
		foreach (cnt_now[c]) begin
			cnt_now[c] = '0;
			cnt_seen[c] = '0;
			for (int iv = 0; iv < NIV; iv++) begin
				iv_rate[c][iv] = '0;
				iv_mark[c][iv] = '0;
			end
		end

		// is_cfg, cfg_val, cmd, idx, inc, sel, typed, value, status
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_CUR, 6'd0, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd63, 32'sd0, IV_DAY,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_ADD, 6'd0, 32'sh7FFF_FFFF, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_ADD, 6'd0, 32'sh8000_0000, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_CUR, 6'd0, 32'sd0, IV_SEC,
			1'b1, -64'sd1, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_DIFF, 6'd0, 32'sd0, IV_SEC,
			1'b1, -64'sd1, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_DIFF, 6'd0, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_ADD, 6'd63, -32'sd5, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_CUR, 6'd63, 32'sd0, IV_SEC,
			1'b1, -64'sd5, STS_OK});
		// tick ignores its index field
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_TICK, 6'd63, 32'sd9, IV_DAY,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd63, 32'sd0, IV_SEC,
			1'b1, -64'sd5, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd63, 32'sd0, IV_MIN,
			1'b1, -64'sd5, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd0, 32'sd0, IV_HOUR,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, CMD_RSVD_LO, 6'd63, 32'sd1, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, CMD_RSVD_HI, 6'd0, 32'sd1, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b1, CFG_ONE, erc_pkg::CMD_ADD, 6'd0, 32'sd0, IV_SEC,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_DIFF, 6'd1, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_RANGE});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_ADD, 6'd63, 32'sd7, IV_SEC,
			1'b1, 64'sd0, STS_RANGE});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_TICK, 6'd0, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd0, 32'sd0, IV_SEC,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b1, CFG_NONE, erc_pkg::CMD_ADD, 6'd0, 32'sd0, IV_SEC,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_CUR, 6'd0, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_RANGE});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_TICK, 6'd0, 32'sd0, IV_SEC,
			1'b1, 64'sd0, STS_OK});
		// register above bank size saturates at the bank size
		dir_steps.push_back({1'b1, CFG_MAX, erc_pkg::CMD_ADD, 6'd0, 32'sd0, IV_SEC,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_CUR, 6'd63, 32'sd0, IV_SEC,
			1'b0, 64'sd0, STS_OK});
		dir_steps.push_back({1'b0, CFG_NONE, erc_pkg::CMD_RATE, 6'd63, 32'sd0, IV_MIN,
			1'b0, 64'sd0, STS_OK});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		recv_stall_pct = 20;
		foreach (dir_steps[i]) begin
			s = dir_steps[i];
			if (s.is_cfg)
				set_active(s.cfg_val);
			else
				push_word(s.cmd, s.idx, s.inc, s.sel, s.typed, s.value, s.status);
		end

		// timebase walk: cross a minute boundary, run mixed traffic, then cross the next one
		send_idle_pct = 0;
		recv_stall_pct = 0;
		tick_to(SECS_MIN - 1);
		set_active(7'd3);
		for (int c = 0; c < 3; c++)
			push_word(erc_pkg::CMD_ADD, 6'(c), $urandom(), IV_SEC);
		push_word(erc_pkg::CMD_TICK, 6'($urandom()), $urandom(), 2'($urandom()));
		for (int c = 0; c < 3; c++)
			for (int iv = 0; iv < NIV; iv++)
				push_word(erc_pkg::CMD_RATE, 6'(c), 32'sd0, 2'(iv));
		for (int k = 0; k < 200; k++) begin
			case ($urandom_range(3))
				0: push_word(erc_pkg::CMD_TICK, 6'($urandom()), $urandom(), 2'($urandom()));
				1: push_word(erc_pkg::CMD_RATE, 6'($urandom_range(2)), 32'sd0,
					2'($urandom()));
				default: push_word(erc_pkg::CMD_ADD, 6'($urandom_range(2)), $urandom(),
					IV_SEC);
			endcase
		end
		tick_to((day_pos / SECS_MIN + 1) * SECS_MIN - 1);
		set_active(7'd3);
		for (int c = 0; c < 3; c++)
			push_word(erc_pkg::CMD_ADD, 6'(c), $urandom(), IV_SEC);
		push_word(erc_pkg::CMD_TICK, 6'($urandom()), $urandom(), 2'($urandom()));
		for (int c = 0; c < 3; c++) begin
			for (int iv = 0; iv < NIV; iv++)
				push_word(erc_pkg::CMD_RATE, 6'(c), 32'sd0, 2'(iv));
			push_word(erc_pkg::CMD_DIFF, 6'(c), 32'sd0, IV_SEC);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_active(erc_pkg::CFG_RESET);
				1: set_active(CFG_MAX);
				2: set_active(7'($urandom_range(2, NCNT - 1)));
				default: set_active(7'($urandom_range(1, NCNT)));
			endcase
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver goes quiet while words keep coming, backing up the input
				if (ph == 0 && k == 50)
					hold_go <= 1'b1;
				push_random();
			end
		end

		settle();
		repeat (2 + 3 * NCNT) @(posedge clk);

		$display("checked %0d result words: %0d adds, %0d differences, %0d ticks,",
			checked, cmd_hits[erc_pkg::CMD_ADD], cmd_hits[erc_pkg::CMD_DIFF],
			cmd_hits[erc_pkg::CMD_TICK]);
		$display("%0d rate reads, %0d current reads, %0d reserved, %0d out of range;",
			cmd_hits[erc_pkg::CMD_RATE], cmd_hits[erc_pkg::CMD_CUR],
			cmd_hits[5] + cmd_hits[6] + cmd_hits[7], range_errors);
		$display("%0d register writes, %0d minute boundaries crossed", cfg_writes,
			minute_wraps);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
